/* design/pdcp_dd_pkg.sv */
// Shared constants, codes and control types of the receive duplicate-discard block.
package pdcp_dd_pkg;

  localparam int NUM_UES  = 8;
  localparam int SN_SPACE = 4096;
  localparam int MAX_SN   = 4095;

  localparam int SN_W     = $clog2(SN_SPACE);
  localparam int DELAY_W  = 16;
  localparam int MAXD_W   = 10;
  localparam int UEIDX_W  = 3;
  localparam int UE_W     = (NUM_UES > 1) ? $clog2(NUM_UES) : 1;
  localparam int VERDICT_W = 2;

  localparam int ROW_W     = 128;
  localparam int BIT_W     = $clog2(ROW_W);
  localparam int ROWS      = SN_SPACE / ROW_W;
  localparam int ROWSEL_W  = $clog2(ROWS);
  localparam int MEM_DEPTH = NUM_UES * ROWS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int LOW_CLEAR_END     = 4000;
  localparam int BOUND_ROW         = LOW_CLEAR_END / ROW_W;
  localparam int BOUND_BIT         = LOW_CLEAR_END % ROW_W;
  localparam int RECOVER_LOW       = 2000;
  localparam int RECOVER_HIGH      = 3000;
  localparam int DEFAULT_MAX_DELAY = 100;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_UE_INDEX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 1'd1;

  localparam logic [VERDICT_W-1:0] VERDICT_DELIVER = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DUP     = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_LATE    = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

/* design/pdcp_dd_ctrl.sv */
// Controller: sequences the bitmap read and the read-modify-write commit of each beat.
module pdcp_dd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pdcp_dd_pkg::status_t  status,
  output pdcp_dd_pkg::cmd_t     cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_MODIFY = 1'b1;

  logic state;
  logic state_next;

  assign in_stall   = (state != ST_IDLE);
  assign cmd.rd_en  = (state == ST_IDLE) && in_valid;
  assign cmd.commit = (state == ST_MODIFY) && status.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/pdcp_dd_dp.sv */
// Datapath: seen-bitmap memory with row valid flags, sequence state and result register.
module pdcp_dd_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pdcp_dd_pkg::cmd_t                      cmd,
  output pdcp_dd_pkg::status_t                   status,
  input  logic                                   cfg_wen,
  input  logic [pdcp_dd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdcp_dd_pkg::CFG_W-1:0]          cfg_data,
  input  logic [pdcp_dd_pkg::SN_W-1:0]           sequence_number,
  input  logic [pdcp_dd_pkg::DELAY_W-1:0]        delay_ms,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [pdcp_dd_pkg::VERDICT_W-1:0]      verdict,
  output logic                                   wrapped
);

  logic [pdcp_dd_pkg::UEIDX_W-1:0]  ue_index;
  logic [pdcp_dd_pkg::MAXD_W-1:0]   max_delay_ms;
  logic [pdcp_dd_pkg::UE_W-1:0]     ue_sel;

  logic [pdcp_dd_pkg::ROW_W-1:0]    mem [pdcp_dd_pkg::MEM_DEPTH];
  logic [pdcp_dd_pkg::ROW_W-1:0]    rd_data;
  logic [pdcp_dd_pkg::ADDR_W-1:0]   rd_addr;
  logic [pdcp_dd_pkg::ADDR_W-1:0]   wr_addr;
  logic [pdcp_dd_pkg::ROW_W-1:0]    wr_data;
  logic [pdcp_dd_pkg::ROW_W-1:0]    mask;
  logic [pdcp_dd_pkg::ROW_W-1:0]    eff;

  logic [pdcp_dd_pkg::NUM_UES-1:0][pdcp_dd_pkg::ROWS-1:0] row_valid;
  logic [pdcp_dd_pkg::NUM_UES-1:0]  bnd_hi;

  logic [pdcp_dd_pkg::SN_W-1:0]     sn_r;
  logic [pdcp_dd_pkg::DELAY_W-1:0]  delay_r;
  logic [pdcp_dd_pkg::ROWSEL_W-1:0] row_r;
  logic [pdcp_dd_pkg::BIT_W-1:0]    bit_r;

  logic [pdcp_dd_pkg::SN_W-1:0]     next_expected;
  logic                             wrap_pending;
  logic [pdcp_dd_pkg::SN_W:0]       sn_inc;
  logic [pdcp_dd_pkg::SN_W-1:0]     ne_new;
  logic                             seen;
  logic                             wrap;
  logic                             recover;
  logic                             first_commit;

  assign ue_sel  = pdcp_dd_pkg::UE_W'(ue_index % pdcp_dd_pkg::NUM_UES);
  assign row_r   = sn_r[pdcp_dd_pkg::SN_W-1 -: pdcp_dd_pkg::ROWSEL_W];
  assign bit_r   = sn_r[pdcp_dd_pkg::BIT_W-1:0];
  assign rd_addr = {ue_sel, sequence_number[pdcp_dd_pkg::SN_W-1 -: pdcp_dd_pkg::ROWSEL_W]};
  assign wr_addr = {ue_sel, row_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      ue_index     <= '0;
      max_delay_ms <= pdcp_dd_pkg::MAXD_W'(pdcp_dd_pkg::DEFAULT_MAX_DELAY);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pdcp_dd_pkg::REG_UE_INDEX:  ue_index     <= cfg_data[pdcp_dd_pkg::UEIDX_W-1:0];
        pdcp_dd_pkg::REG_MAX_DELAY: max_delay_ms <= cfg_data[pdcp_dd_pkg::MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
      sn_r    <= sequence_number;
      delay_r <= delay_ms;
    end
    if (first_commit) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    for (int b = 0; b < pdcp_dd_pkg::ROW_W; b++) begin
      if ((row_r == pdcp_dd_pkg::ROWSEL_W'(pdcp_dd_pkg::BOUND_ROW)) &&
          (b >= pdcp_dd_pkg::BOUND_BIT)) begin
        mask[b] = bnd_hi[ue_sel];
      end else begin
        mask[b] = row_valid[ue_sel][row_r];
      end
    end
  end

  assign eff     = rd_data & mask;
  assign seen    = eff[bit_r];
  assign wr_data = eff | (pdcp_dd_pkg::ROW_W'(1) << bit_r);

  assign sn_inc  = {1'b0, sn_r} + (pdcp_dd_pkg::SN_W + 1)'(1);
  assign wrap    = (sn_inc >= (pdcp_dd_pkg::SN_W + 1)'(pdcp_dd_pkg::MAX_SN)) ||
                   (sn_inc < {1'b0, next_expected});
  assign ne_new  = wrap ? '0 : sn_inc[pdcp_dd_pkg::SN_W-1:0];
  assign recover = !wrap && wrap_pending &&
                   (ne_new > pdcp_dd_pkg::SN_W'(pdcp_dd_pkg::RECOVER_LOW)) &&
                   (ne_new < pdcp_dd_pkg::SN_W'(pdcp_dd_pkg::RECOVER_HIGH));
  assign first_commit = cmd.commit && !seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid     <= '0;
      bnd_hi        <= '0;
      next_expected <= '0;
      wrap_pending  <= 1'b0;
    end else if (first_commit) begin
      next_expected <= ne_new;
      for (int r = 0; r < pdcp_dd_pkg::ROWS; r++) begin
        if (wrap && (r <= pdcp_dd_pkg::BOUND_ROW)) begin
          row_valid[ue_sel][r] <= 1'b0;
        end else if (recover && (r > pdcp_dd_pkg::BOUND_ROW)) begin
          row_valid[ue_sel][r] <= 1'b0;
        end else if (r == int'(row_r)) begin
          row_valid[ue_sel][r] <= 1'b1;
        end
      end
      if (recover) begin
        bnd_hi[ue_sel] <= 1'b0;
      end else if (row_r == pdcp_dd_pkg::ROWSEL_W'(pdcp_dd_pkg::BOUND_ROW)) begin
        bnd_hi[ue_sel] <= 1'b1;
      end
      if (wrap) begin
        wrap_pending <= 1'b1;
      end else if (recover) begin
        wrap_pending <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      wrapped <= !seen && wrap;
      if (seen) begin
        verdict <= pdcp_dd_pkg::VERDICT_DUP;
      end else if (delay_r < {{(pdcp_dd_pkg::DELAY_W - pdcp_dd_pkg::MAXD_W){1'b0}},
                              max_delay_ms}) begin
        verdict <= pdcp_dd_pkg::VERDICT_DELIVER;
      end else begin
        verdict <= pdcp_dd_pkg::VERDICT_LATE;
      end
    end
  end

  a_no_rd_and_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_en && cmd.commit))
    else $error("bitmap read and commit in the same cycle");

  a_wrap_state: assert property (@(posedge clk) disable iff (rst)
    first_commit && wrap |=> (next_expected == '0) && wrap_pending)
    else $error("wrap did not reset next expected number");

  a_dup_no_change: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && seen |=> $stable(next_expected) && $stable(wrap_pending))
    else $error("duplicate changed sequence state");

  a_recover_drops: assert property (@(posedge clk) disable iff (rst)
    first_commit && recover |=> !wrap_pending)
    else $error("recovery did not drop wrap flag");

  a_wrapped_not_dup: assert property (@(posedge clk) disable iff (rst)
    out_valid && wrapped |-> (verdict != pdcp_dd_pkg::VERDICT_DUP))
    else $error("duplicate reported as wrap");

endmodule

/* design/pdcp_rx_duplicate_discard.sv */
// Top level of the receive duplicate-discard block: controller plus datapath.
// Result: the input beat and its bitmap row are registered on acceptance, and the verdict at
// commit, which waits while a result beat is stalled. A new beat is not taken until the last
// commits, since each needs the read then write of one row in the single-port seen-bitmap memory.
// Reset: clears row valid flags and sequence state and loads config defaults at once; no clearing pass.
module pdcp_rx_duplicate_discard (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [pdcp_dd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdcp_dd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pdcp_dd_pkg::SN_W-1:0]         sequence_number,
  input  logic [pdcp_dd_pkg::DELAY_W-1:0]      delay_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pdcp_dd_pkg::VERDICT_W-1:0]    verdict,
  output logic                                 wrapped
);

  pdcp_dd_pkg::cmd_t    cmd;
  pdcp_dd_pkg::status_t status;

  pdcp_dd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pdcp_dd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sequence_number (sequence_number),
    .delay_ms        (delay_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .verdict         (verdict),
    .wrapped         (wrapped)
  );

endmodule

/* test/pdcp_dd_verdict_checker.sv */
// Checker for the receive duplicate-discard block: tracks the seen bitmap and compares verdicts.
module pdcp_dd_verdict_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [pdcp_dd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdcp_dd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [pdcp_dd_pkg::SN_W-1:0]         sequence_number,
  input  logic [pdcp_dd_pkg::DELAY_W-1:0]      delay_ms,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [pdcp_dd_pkg::VERDICT_W-1:0]    verdict,
  input  logic                                 wrapped,
  output int                                   mismatches,
  output int                                   waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pdcp_dd_pkg::VERDICT_W-1:0] verdict;
    logic                              wrapped;
  } pdu_outcome_t;

  bit                              seen [pdcp_dd_pkg::NUM_UES][pdcp_dd_pkg::SN_SPACE];
  logic [pdcp_dd_pkg::SN_W-1:0]    next_sn;
  bit                              wrap_armed;
  logic [pdcp_dd_pkg::UEIDX_W-1:0] ue_sel;
  logic [pdcp_dd_pkg::MAXD_W-1:0]  delay_limit;
  pdu_outcome_t                    expected_outcomes[$];

  function automatic pdu_outcome_t predict_outcome(
      input logic [pdcp_dd_pkg::SN_W-1:0] sn,
      input logic [pdcp_dd_pkg::DELAY_W-1:0] dly);
    pdu_outcome_t res;
    int ue;
    int succ;
    ue = ue_sel % pdcp_dd_pkg::NUM_UES;
    succ = int'(sn) + 1;
    res.wrapped = 1'b0;
    if (seen[ue][sn]) begin
      res.verdict = pdcp_dd_pkg::VERDICT_DUP;
    end else begin
      res.verdict = (dly < delay_limit) ? pdcp_dd_pkg::VERDICT_DELIVER
                                        : pdcp_dd_pkg::VERDICT_LATE;
      seen[ue][sn] = 1'b1;
      if (succ >= pdcp_dd_pkg::MAX_SN || succ < int'(next_sn)) begin
        wrap_armed = 1'b1;
        next_sn = '0;
        for (int i = 0; i < pdcp_dd_pkg::LOW_CLEAR_END; i++) seen[ue][i] = 1'b0;
        res.wrapped = 1'b1;
      end else begin
        next_sn = succ[pdcp_dd_pkg::SN_W-1:0];
      end
      if (int'(next_sn) > pdcp_dd_pkg::RECOVER_LOW &&
          int'(next_sn) < pdcp_dd_pkg::RECOVER_HIGH && wrap_armed) begin
        wrap_armed = 1'b0;
        for (int i = pdcp_dd_pkg::LOW_CLEAR_END; i < pdcp_dd_pkg::SN_SPACE; i++)
          seen[ue][i] = 1'b0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pdu_outcome_t want;
    if (rst) begin
      for (int u = 0; u < pdcp_dd_pkg::NUM_UES; u++)
        for (int s = 0; s < pdcp_dd_pkg::SN_SPACE; s++) seen[u][s] = 1'b0;
      next_sn = '0;
      wrap_armed = 1'b0;
      ue_sel = '0;
      delay_limit = pdcp_dd_pkg::MAXD_W'(pdcp_dd_pkg::DEFAULT_MAX_DELAY);
      expected_outcomes.delete();
      mismatches = 0;
    end else begin
      if (cfg_wen) begin
        if (cfg_index == pdcp_dd_pkg::REG_UE_INDEX)
          ue_sel = cfg_data[pdcp_dd_pkg::UEIDX_W-1:0];
        else if (cfg_index == pdcp_dd_pkg::REG_MAX_DELAY)
          delay_limit = cfg_data[pdcp_dd_pkg::MAXD_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result beat: verdict %0d wrapped %0d",
                     $realtime, verdict, wrapped);
          mismatches = mismatches + 1;
        end else begin
          want = expected_outcomes.pop_front();
          if (verdict !== want.verdict || wrapped !== want.wrapped) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected verdict %0d wrapped %0d, got %0d %0d",
                       $realtime, want.verdict, want.wrapped, verdict, wrapped);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_outcomes.push_back(predict_outcome(sequence_number, delay_ms));
    end
    waiting = expected_outcomes.size();
  end

endmodule

/* test/pdcp_rx_duplicate_discard_tb.sv */
// Testbench top for the receive duplicate-discard block: stimulus, receiver stalls and verdict.
module pdcp_rx_duplicate_discard_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 6;
  localparam int PHASE_PDUS  = 115;
  localparam int HOLD_CYCLES = 300;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 cfg_wen;
  logic [pdcp_dd_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [pdcp_dd_pkg::CFG_W-1:0]        cfg_data;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [pdcp_dd_pkg::SN_W-1:0]         sequence_number;
  logic [pdcp_dd_pkg::DELAY_W-1:0]      delay_ms;
  logic                                 out_valid;
  logic                                 out_stall;
  logic [pdcp_dd_pkg::VERDICT_W-1:0]    verdict;
  logic                                 wrapped;

  int mismatches;
  int waiting;
  int quiet_cycles = 0;
  int sn_cursor;
  int delay_cap;
  bit calm;
  bit hold_req;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pdcp_rx_duplicate_discard DUT (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sequence_number(sequence_number), .delay_ms(delay_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .verdict(verdict), .wrapped(wrapped)
  );

  pdcp_dd_verdict_checker verdict_chk (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sequence_number(sequence_number), .delay_ms(delay_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .verdict(verdict), .wrapped(wrapped),
    .mismatches(mismatches), .waiting(waiting)
  );

  task automatic configure(input int ue, input int max_delay);
    cfg_wen <= 1'b1;
    cfg_index <= pdcp_dd_pkg::REG_UE_INDEX;
    cfg_data <= pdcp_dd_pkg::CFG_W'(ue);
    @(posedge clk);
    cfg_index <= pdcp_dd_pkg::REG_MAX_DELAY;
    cfg_data <= pdcp_dd_pkg::CFG_W'(max_delay);
    @(posedge clk);
    cfg_wen <= 1'b0;
    delay_cap = max_delay;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (waiting == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic drive_pdu(input int sn, input int dly);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sequence_number <= pdcp_dd_pkg::SN_W'(sn);
    delay_ms <= pdcp_dd_pkg::DELAY_W'(dly);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_pdu();
    int pick;
    int sn;
    int dly;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      sn_cursor = (sn_cursor + $urandom_range(1, 150)) % pdcp_dd_pkg::SN_SPACE;
      sn = sn_cursor;
    end else if (pick < 82) begin
      sn = (sn_cursor + pdcp_dd_pkg::SN_SPACE - $urandom_range(0, 3)) % pdcp_dd_pkg::SN_SPACE;
    end else if (pick < 92) begin
      sn_cursor = (sn_cursor + pdcp_dd_pkg::SN_SPACE - $urandom_range(1, 1500))
                  % pdcp_dd_pkg::SN_SPACE;
      sn = sn_cursor;
    end else begin
      sn_cursor = $urandom_range(0, pdcp_dd_pkg::SN_SPACE - 1);
      sn = sn_cursor;
    end
    if ($urandom_range(0, 99) < 15) dly = $urandom_range(0, 65535);
    else dly = $urandom_range(0, 2 * delay_cap + 1);
    drive_pdu(sn, dly);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_index <= pdcp_dd_pkg::REG_UE_INDEX;
    cfg_data <= '0;
    in_valid <= 1'b0;
    sequence_number <= '0;
    delay_ms <= '0;
    calm = 1'b0;
    hold_req = 1'b0;
    sn_cursor = 0;
    delay_cap = pdcp_dd_pkg::DEFAULT_MAX_DELAY;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default limit: duplicate, limit edges, wrap at the top, low and high range clears
    drive_pdu(0, 0);
    drive_pdu(0, 65535);
    drive_pdu(1, 99);
    drive_pdu(2, 100);
    drive_pdu(4000, 0);
    drive_pdu(4093, 0);
    drive_pdu(4094, 0);
    drive_pdu(4000, 0);
    drive_pdu(0, 0);
    drive_pdu(2500, 0);
    drive_pdu(4000, 0);
    drive_pdu(4095, 65535);
    drive_pdu(4095, 0);
    drive_pdu(1999, 1);
    drive_pdu(2999, 1);
    drive_pdu(2000, 1);
    drive_pdu(2000, 0);
    settle();

    // zero limit on the highest UE
    configure(7, 0);
    drive_pdu(0, 0);
    drive_pdu(4095, 0);
    drive_pdu(5, 65535);
    settle();

    configure(3, 1000);
    drive_pdu(6, 999);
    drive_pdu(7, 1000);

    for (int ph = 0; ph < PHASES; ph++) begin
      int ue;
      int max_delay;
      settle();
      case (ph)
        0: begin ue = 0; max_delay = 1000; end
        1: begin ue = 7; max_delay = 0; end
        2: begin ue = $urandom_range(0, 7); max_delay = 100; end
        default: begin ue = $urandom_range(0, 7); max_delay = $urandom_range(1, 999); end
      endcase
      configure(ue, max_delay);
      calm = (ph == 3) || ($urandom_range(0, 4) == 0);
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < PHASE_PDUS; i++) begin
        if (ph != 3 && i % 25 == 24) calm = ($urandom_range(0, 3) == 0);
        random_pdu();
      end
    end
    calm = 1'b0;
    settle();

    if (mismatches == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int n;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 14);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wen || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
